// ===== rtl/fcil_pkg.sv =====
// ----------------------------------------------------------------------------
// fcil_pkg: shared types and constants
// operation and status codes, command classes and the command word that
// travels from the front end to the execution back end
// ----------------------------------------------------------------------------
package fcil_pkg;

   // storage size and derived widths
   localparam int DEPTH    = 64;
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int WORD_W   = 32;
   localparam int OP_W     = 3;
   localparam int POS_W    = 7;
   localparam int CAP_W    = 8;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   // compare width wide enough for count, position and capacity
   localparam int WIDE_A = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int WIDE_W = (WIDE_A > CAP_W + 1) ? WIDE_A : CAP_W + 1;

   // operation codes
   localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP = 3'd2;
   localparam logic [OP_W-1:0] OP_PUSH   = 3'd3;
   localparam logic [OP_W-1:0] OP_POP    = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

   typedef enum logic [2:0] {
      KIND_INSERT,
      KIND_PUSH,
      KIND_REMOVE,
      KIND_POP,
      KIND_LOOKUP,
      KIND_NOP
   } kind_type;

   typedef struct packed {
      kind_type                   kind;
      logic [POS_W-1:0]           position;
      logic signed [WORD_W-1:0]   word;
   } cmd_type;

endpackage

// ===== rtl/fcil_ram.sv =====
// ----------------------------------------------------------------------------
// fcil_ram: generic single-write, single-read memory
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module fcil_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/fcil_front.sv =====
// ----------------------------------------------------------------------------
// fcil_front: request intake
// decodes the operation code into a command class and holds commands in a
// two-entry queue ahead of the back end
// ----------------------------------------------------------------------------
module fcil_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic [fcil_pkg::OP_W-1:0]             req_operation,
   input  logic [fcil_pkg::POS_W-1:0]            req_position,
   input  logic signed [fcil_pkg::WORD_W-1:0]    req_word_in,
   output logic                                  cmd_valid,
   output fcil_pkg::cmd_type                     cmd,
   input  logic                                  cmd_take
);

   fcil_pkg::cmd_type slot_ff [2];
   fcil_pkg::cmd_type slot_in;
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        fill_ff, fill_in;
   fcil_pkg::kind_type kind;
   logic              push_ok;
   logic              pop_ok;

   always_comb begin
      unique case (req_operation)
         fcil_pkg::OP_INSERT: kind = fcil_pkg::KIND_INSERT;
         fcil_pkg::OP_REMOVE: kind = fcil_pkg::KIND_REMOVE;
         fcil_pkg::OP_LOOKUP: kind = fcil_pkg::KIND_LOOKUP;
         fcil_pkg::OP_PUSH:   kind = fcil_pkg::KIND_PUSH;
         fcil_pkg::OP_POP:    kind = fcil_pkg::KIND_POP;
         default:             kind = fcil_pkg::KIND_NOP;
      endcase
   end

   assign req_full  = (fill_ff == 2'd2);
   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_take && cmd_valid;

   always_comb begin
      slot_in.kind     = kind;
      slot_in.position = req_position;
      slot_in.word     = req_word_in;
      wr_ptr_in        = push_ok ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in        = pop_ok ? !rd_ptr_ff : rd_ptr_ff;
      fill_in          = fill_ff + 2'(push_ok) - 2'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= slot_in;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// ===== rtl/fcil_back.sv =====
// ----------------------------------------------------------------------------
// fcil_back: command execution
// checks each command against the count, updates count and fibonacci
// capacity, moves entries one per cycle through the ram and holds the result
// ----------------------------------------------------------------------------
module fcil_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  cmd_valid,
   input  fcil_pkg::cmd_type                     cmd,
   output logic                                  cmd_take,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic signed [fcil_pkg::WORD_W-1:0]    rsp_word_out,
   output logic [fcil_pkg::STATUS_W-1:0]         rsp_status,
   output logic [fcil_pkg::COUNT_W-1:0]          rsp_entry_count,
   output logic [fcil_pkg::CAP_W-1:0]            rsp_capacity_now
);

   localparam int AW = fcil_pkg::ADDR_W;
   localparam int CW = fcil_pkg::CNT_W;
   localparam int WW = fcil_pkg::WIDE_W;
   localparam int PW = fcil_pkg::CAP_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_FETCH,
      S_SHIFT,
      S_DONE
   } state_type;

   state_type                        state_ff, state_in;
   logic [CW-1:0]                    cnt_ff, cnt_in;
   logic [PW-1:0]                    cap_ff, cap_in;
   logic [PW-1:0]                    prev_ff, prev_in;
   logic [AW-1:0]                    src_ff, src_in;
   logic [CW-1:0]                    moves_ff, moves_in;
   logic                             pend_ff, pend_in;
   logic [AW-1:0]                    pend_dst_ff, pend_dst_in;
   logic                             up_ff, up_in;
   logic                             ins_ff, ins_in;
   logic                             rem_ff, rem_in;
   logic [AW-1:0]                    pos_ff, pos_in;
   logic [fcil_pkg::WORD_W-1:0]      word_ff, word_in;
   logic [fcil_pkg::WORD_W-1:0]      res_word_ff, res_word_in;
   logic [fcil_pkg::STATUS_W-1:0]    res_status_ff, res_status_in;
   logic                             out_valid_ff, out_valid_in;
   logic [fcil_pkg::WORD_W-1:0]      out_word_ff, out_word_in;
   logic [fcil_pkg::STATUS_W-1:0]    out_status_ff, out_status_in;
   logic [fcil_pkg::COUNT_W-1:0]     out_count_ff, out_count_in;
   logic [PW-1:0]                    out_cap_ff, out_cap_in;

   logic                             wr_en;
   logic [AW-1:0]                    wr_addr;
   logic [fcil_pkg::WORD_W-1:0]      wr_data;
   logic                             rd_en;
   logic [AW-1:0]                    rd_addr;
   logic [fcil_pkg::WORD_W-1:0]      rd_data;

   logic [WW-1:0]                    cnt_w, pos_w, cap_w, ins_pos_w, rem_pos_w;
   logic [PW:0]                      grow_sum;
   logic [PW-1:0]                    two_below;

   fcil_ram #(
      .WIDTH (fcil_pkg::WORD_W),
      .DEPTH (fcil_pkg::DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign cnt_w     = WW'(cnt_ff);
   assign pos_w     = WW'(cmd.position);
   assign cap_w     = WW'(cap_ff);
   assign ins_pos_w = (cmd.kind == fcil_pkg::KIND_PUSH) ? cnt_w : pos_w;
   assign rem_pos_w = (cmd.kind == fcil_pkg::KIND_POP) ? cnt_w - WW'(1) : pos_w;
   assign grow_sum  = {1'b0, cap_ff} + {1'b0, prev_ff};
   assign two_below = (cap_ff > prev_ff) ? cap_ff - prev_ff : PW'(1);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cap_in        = cap_ff;
      prev_in       = prev_ff;
      src_in        = src_ff;
      moves_in      = moves_ff;
      pend_in       = pend_ff;
      pend_dst_in   = pend_dst_ff;
      up_in         = up_ff;
      ins_in        = ins_ff;
      rem_in        = rem_ff;
      pos_in        = pos_ff;
      word_in       = word_ff;
      res_word_in   = res_word_ff;
      res_status_in = res_status_ff;
      out_valid_in  = out_valid_ff && !rsp_pop;
      out_word_in   = out_word_ff;
      out_status_in = out_status_ff;
      out_count_in  = out_count_ff;
      out_cap_in    = out_cap_ff;
      cmd_take      = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_en         = 1'b0;
      rd_addr       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_take      = 1'b1;
               res_word_in   = '0;
               res_status_in = fcil_pkg::STATUS_OK;
               ins_in        = 1'b0;
               rem_in        = 1'b0;
               pend_in       = 1'b0;
               moves_in      = '0;
               state_in      = S_DONE;
               unique case (cmd.kind)
                  fcil_pkg::KIND_INSERT, fcil_pkg::KIND_PUSH: begin
                     if (ins_pos_w > cnt_w) begin
                        res_status_in = fcil_pkg::STATUS_RANGE;
                     end else if (cnt_w >= WW'(fcil_pkg::DEPTH)) begin
                        res_status_in = fcil_pkg::STATUS_FULL;
                     end else begin
                        // grow when the list is at capacity and the next fits
                        if (cnt_w == cap_w && !grow_sum[PW]) begin
                           prev_in = cap_ff;
                           cap_in  = grow_sum[PW-1:0];
                        end
                        cnt_in   = cnt_ff + CW'(1);
                        moves_in = CW'(cnt_w - ins_pos_w);
                        src_in   = AW'(cnt_w - WW'(1));
                        up_in    = 1'b1;
                        ins_in   = 1'b1;
                        pos_in   = AW'(ins_pos_w);
                        word_in  = cmd.word;
                        state_in = S_SHIFT;
                     end
                  end
                  fcil_pkg::KIND_REMOVE, fcil_pkg::KIND_POP: begin
                     if (cmd.kind == fcil_pkg::KIND_POP && cnt_w == '0) begin
                        res_status_in = fcil_pkg::STATUS_UNDERFLOW;
                     end else if (rem_pos_w >= cnt_w) begin
                        res_status_in = fcil_pkg::STATUS_RANGE;
                     end else begin
                        rd_en   = 1'b1;
                        rd_addr = AW'(rem_pos_w);
                        // shrink when the new count hits the value two below
                        if (cnt_w - WW'(1) == WW'(two_below)) begin
                           cap_in  = prev_ff;
                           prev_in = two_below;
                        end
                        cnt_in   = cnt_ff - CW'(1);
                        moves_in = CW'(cnt_w - WW'(1) - rem_pos_w);
                        src_in   = AW'(rem_pos_w + WW'(1));
                        up_in    = 1'b0;
                        rem_in   = 1'b1;
                        state_in = S_FETCH;
                     end
                  end
                  fcil_pkg::KIND_LOOKUP: begin
                     if (pos_w < cnt_w) begin
                        rd_en    = 1'b1;
                        rd_addr  = AW'(pos_w);
                        state_in = S_FETCH;
                     end else begin
                        res_status_in = fcil_pkg::STATUS_RANGE;
                     end
                  end
                  default: begin
                     res_status_in = fcil_pkg::STATUS_OK;
                  end
               endcase
            end
         end
         S_FETCH: begin
            res_word_in = rd_data;
            state_in    = rem_ff ? S_SHIFT : S_DONE;
         end
         S_SHIFT: begin
            // write back the word read last cycle, then read the next one
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pend_dst_ff;
               wr_data = rd_data;
            end
            if (moves_ff != '0) begin
               rd_en       = 1'b1;
               rd_addr     = src_ff;
               pend_in     = 1'b1;
               pend_dst_in = up_ff ? src_ff + AW'(1) : src_ff - AW'(1);
               src_in      = up_ff ? src_ff - AW'(1) : src_ff + AW'(1);
               moves_in    = moves_ff - CW'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  if (ins_ff) begin
                     wr_en   = 1'b1;
                     wr_addr = pos_ff;
                     wr_data = word_ff;
                  end
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (!out_valid_ff || rsp_pop) begin
               out_valid_in  = 1'b1;
               out_word_in   = res_word_ff;
               out_status_in = res_status_ff;
               out_count_in  = fcil_pkg::COUNT_W'(cnt_ff);
               out_cap_in    = cap_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      src_ff        <= src_in;
      moves_ff      <= moves_in;
      pend_dst_ff   <= pend_dst_in;
      up_ff         <= up_in;
      ins_ff        <= ins_in;
      rem_ff        <= rem_in;
      pos_ff        <= pos_in;
      word_ff       <= word_in;
      res_word_ff   <= res_word_in;
      res_status_ff <= res_status_in;
      out_word_ff   <= out_word_in;
      out_status_ff <= out_status_in;
      out_count_ff  <= out_count_in;
      out_cap_ff    <= out_cap_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         cap_ff       <= PW'(1);
         prev_ff      <= PW'(1);
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         cap_ff       <= cap_in;
         prev_ff      <= prev_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_word_out     = out_word_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_entry_count  = out_count_ff;
   assign rsp_capacity_now = out_cap_ff;

endmodule

// ===== rtl/fibonacci_capacity_insert_list_top.sv =====
// ----------------------------------------------------------------------------
// fibonacci_capacity_insert_list_top: ordered word list with fibonacci capacity
// insert, push, remove, pop and lookup on a list of signed 32-bit words
// ----------------------------------------------------------------------------
// flow: errors and spare codes go idle, done; lookup idle, fetch, done; insert idle,
//   shift, done; remove idle, fetch, shift, done; shift moves up to 63 entries
// throughput: one command at a time in the back end, busy until its result is registered, as the
//   single ram port pair moves one entry per cycle; a waiting result stalls it
// reset: synchronous; count 0, capacity pair 1/1, queues empty; ram contents
//   are left as they are and never read before being written
module fibonacci_capacity_insert_list_top (
   input  logic                                  clock,
   input  logic                                  reset,
   // request side
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic [fcil_pkg::OP_W-1:0]             req_operation,
   input  logic [fcil_pkg::POS_W-1:0]            req_position,
   input  logic signed [fcil_pkg::WORD_W-1:0]    req_word_in,
   // response side
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic signed [fcil_pkg::WORD_W-1:0]    rsp_word_out,
   output logic [fcil_pkg::STATUS_W-1:0]         rsp_status,
   output logic [fcil_pkg::COUNT_W-1:0]          rsp_entry_count,
   output logic [fcil_pkg::CAP_W-1:0]            rsp_capacity_now
);

   // classified command word between front and back
   fcil_pkg::cmd_type cmd;
   logic              cmd_valid;
   logic              cmd_take;

   // front: decode the operation and queue the command
   fcil_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_operation (req_operation),
      .req_position  (req_position),
      .req_word_in   (req_word_in),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_take      (cmd_take)
   );

   // back: range checks, capacity tracking, entry moves and result register
   fcil_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_take         (cmd_take),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_word_out     (rsp_word_out),
      .rsp_status       (rsp_status),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_capacity_now (rsp_capacity_now)
   );

endmodule

// ===== rtl/fcil_checker.sv =====
// ----------------------------------------------------------------------------
// fcil_checker: port-level checks
// watches the top level ports for result consistency over time
// ----------------------------------------------------------------------------
module fcil_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_empty,
   input logic                                  rsp_pop,
   input logic signed [fcil_pkg::WORD_W-1:0]    rsp_word_out,
   input logic [fcil_pkg::STATUS_W-1:0]         rsp_status,
   input logic [fcil_pkg::COUNT_W-1:0]          rsp_entry_count,
   input logic [fcil_pkg::CAP_W-1:0]            rsp_capacity_now
);

   // no result is shown right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result shown after reset");

   // a full report only happens with the list at its limit
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status == fcil_pkg::STATUS_FULL)
      |-> rsp_entry_count == fcil_pkg::COUNT_W'(fcil_pkg::DEPTH))
      else $error("full status with list below limit");

   // an underflow leaves an empty list and a zero word
   a_underflow: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status == fcil_pkg::STATUS_UNDERFLOW)
      |-> (rsp_entry_count == '0 && rsp_word_out == '0))
      else $error("underflow with entries or nonzero word");

   // a waiting result stays put until popped
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop)
      |=> (!rsp_empty && $stable(rsp_word_out) && $stable(rsp_status)
           && $stable(rsp_entry_count) && $stable(rsp_capacity_now)))
      else $error("waiting result changed");

endmodule

bind fibonacci_capacity_insert_list_top fcil_checker u_fcil_checker (.*);

// ===== tb/tb_fibonacci_capacity_insert_list_top.sv =====
// ----------------------------------------------------------------------------
// tb_fibonacci_capacity_insert_list_top: self-checking bench for the fib list
// drives insert, push, remove, pop, lookup and spare codes through the request
// queue, predicts every response word with a local list model and checks each
// popped word field by field; both sides idle at random
// ----------------------------------------------------------------------------
module tb_fibonacci_capacity_insert_list_top;
   import fcil_pkg::*;

   // spare operation codes, the block answers them without changing anything
   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
   localparam logic [POS_W-1:0] POS_MAX    = 7'd127;

   localparam int RANDOM_ITEMS = 2000;
   localparam int STALL_LIMIT  = 4000;   // cycles without any accepted word
   localparam int TAIL_CYCLES  = 150;    // longest move plus pipeline, with margin
   localparam int CAP_LIMIT    = 255;    // capacity must fit in 8 bits

   typedef enum int {MIX_GROW, MIX_SHRINK, MIX_BALANCED} mix_type;

   // one request word, plus a flag that holds it until all replies are back
   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic [POS_W-1:0]         pos;
      logic signed [WORD_W-1:0] word;
      bit                       drain_first;
   } req_item_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] word;
      logic [STATUS_W-1:0]      status;
      logic [COUNT_W-1:0]       count;
      logic [CAP_W-1:0]         cap;
   } reply_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_push = 1'b0;
   logic                        req_full;
   logic [OP_W-1:0]             req_operation = '0;
   logic [POS_W-1:0]            req_position = '0;
   logic signed [WORD_W-1:0]    req_word_in = '0;
   logic                        rsp_empty;
   logic                        rsp_pop = 1'b0;
   logic signed [WORD_W-1:0]    rsp_word_out;
   logic [STATUS_W-1:0]         rsp_status;
   logic [COUNT_W-1:0]          rsp_entry_count;
   logic [CAP_W-1:0]            rsp_capacity_now;

   req_item_type pending_words[$];
   reply_type    expected_replies[$];
   int unsigned mismatch_count = 0;
   int unsigned stall_cycles = 0;
   int unsigned planned_count = 0;   // list length the stimulus plan will leave

   // list model state
   logic signed [WORD_W-1:0] model_words [0:DEPTH-1];
   int unsigned model_count = 0;
   int unsigned model_cap   = 1;
   int unsigned model_prev  = 1;

   // idle control, one set per side
   int unsigned req_gap = 0;
   int unsigned req_quiet = 0;
   int unsigned rsp_gap = 0;
   int unsigned rsp_quiet = 0;

   fibonacci_capacity_insert_list_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_operation    (req_operation),
      .req_position     (req_position),
      .req_word_in      (req_word_in),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_word_out     (rsp_word_out),
      .rsp_status       (rsp_status),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_capacity_now (rsp_capacity_now)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // list model
   // ---------------------------------------------------------------------

   // insert at pos, shifting later entries up; grows the fib pair when full
   function automatic logic [STATUS_W-1:0] model_insert(input int unsigned pos,
                                                        input logic signed [WORD_W-1:0] w);
      int unsigned i;
      if (pos > model_count) return STATUS_RANGE;
      if (model_count >= DEPTH) return STATUS_FULL;
      if (model_count == model_cap && model_cap + model_prev <= CAP_LIMIT) begin
         i          = model_cap + model_prev;
         model_prev = model_cap;
         model_cap  = i;
      end
      for (i = model_count; i > pos; i--) model_words[i] = model_words[i-1];
      model_words[pos] = w;
      model_count++;
      return STATUS_OK;
   endfunction

   // remove at pos, shifting later entries down; shrinks at two fibs below
   function automatic logic [STATUS_W-1:0] model_remove(input int unsigned pos,
                                                        output logic signed [WORD_W-1:0] w);
      int unsigned i;
      int unsigned lower;
      w = '0;
      if (pos >= model_count) return STATUS_RANGE;
      w     = model_words[pos];
      // value below the bottom of the series counts as one
      lower = (model_cap > model_prev) ? model_cap - model_prev : 1;
      if (model_count - 1 == lower) begin
         model_cap  = model_prev;
         model_prev = lower;
      end
      model_count--;
      for (i = pos; i < model_count; i++) model_words[i] = model_words[i+1];
      return STATUS_OK;
   endfunction

   function automatic reply_type list_apply(input logic [OP_W-1:0] op,
                                            input logic [POS_W-1:0] pos,
                                            input logic signed [WORD_W-1:0] w);
      reply_type r;
      logic signed [WORD_W-1:0] taken_word;
      r = '0;
      taken_word = '0;
      case (op)
         OP_INSERT: r.status = model_insert(pos, w);
         OP_PUSH:   r.status = model_insert(model_count, w);
         OP_REMOVE: r.status = model_remove(pos, taken_word);
         OP_POP: begin
            if (model_count == 0) r.status = STATUS_UNDERFLOW;
            else r.status = model_remove(model_count - 1, taken_word);
         end
         OP_LOOKUP: begin
            if (pos < model_count) taken_word = model_words[pos];
            else r.status = STATUS_RANGE;
         end
         default: r.status = STATUS_OK;   // spare codes change nothing
      endcase
      r.word  = taken_word;
      r.count = model_count[COUNT_W-1:0];
      r.cap   = model_cap[CAP_W-1:0];
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus planning
   // ---------------------------------------------------------------------

   // mostly back to back, some short gaps, a few long ones, quiet stretches
   function automatic int unsigned idle_gap(inout int unsigned quiet_left);
      int unsigned r;
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      if ($urandom_range(49, 0) == 0) begin
         quiet_left = $urandom_range(80, 20);
         return 0;
      end
      r = $urandom_range(99, 0);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // queue one word and track the list length it will leave behind
   task automatic plan(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                       input logic signed [WORD_W-1:0] w, input bit drain);
      req_item_type it;
      it.op          = op;
      it.pos         = pos;
      it.word        = w;
      it.drain_first = drain;
      pending_words.push_back(it);
      case (op)
         OP_INSERT: if (pos <= planned_count && planned_count < DEPTH) planned_count++;
         OP_PUSH:   if (planned_count < DEPTH) planned_count++;
         OP_REMOVE: if (pos < planned_count) planned_count--;
         OP_POP:    if (planned_count > 0) planned_count--;
         default: ;
      endcase
   endtask

   // any position over the full field range
   function automatic logic [POS_W-1:0] any_pos();
      return POS_W'($urandom_range(POS_MAX, 0));
   endfunction

   // position for insert: mostly in range (0..count), sometimes past it
   function automatic logic [POS_W-1:0] insert_pos();
      if ($urandom_range(99, 0) < 85) return POS_W'($urandom_range(planned_count, 0));
      return POS_W'($urandom_range(POS_MAX, planned_count + 1));
   endfunction

   // position for remove and lookup: mostly a live entry, sometimes not
   function automatic logic [POS_W-1:0] entry_pos();
      if (planned_count > 0 && $urandom_range(99, 0) < 85)
         return POS_W'($urandom_range(planned_count - 1, 0));
      return POS_W'($urandom_range(POS_MAX, planned_count));
   endfunction

   // ---------------------------------------------------------------------
   // request driver
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive_requests
      bit           taken;
      req_item_type head;
      taken = req_push && !req_full;
      if (reset) begin
         req_push <= 1'b0;
      end else if (!req_push || taken) begin
         // predict the reply as soon as the word is accepted
         if (taken) begin
            expected_replies.push_back(list_apply(req_operation, req_position, req_word_in));
            req_gap = idle_gap(req_quiet);
         end
         if (req_gap > 0) begin
            req_gap--;
            req_push <= 1'b0;
         end else if (pending_words.size() > 0 &&
                      (!pending_words[0].drain_first || expected_replies.size() == 0)) begin
            head = pending_words.pop_front();
            req_push      <= 1'b1;
            req_operation <= head.op;
            req_position  <= head.pos;
            req_word_in   <= head.word;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // response monitor
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_replies
      reply_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_replies.size() == 0) begin
               $error("reply with none pending: word_out %0d status %0d",
                      rsp_word_out, rsp_status);
               mismatch_count++;
            end else begin
               want = expected_replies.pop_front();
               if (rsp_word_out !== want.word) begin
                  $error("word_out: expected %0d, got %0d", want.word, rsp_word_out);
                  mismatch_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  mismatch_count++;
               end
               if (rsp_entry_count !== want.count) begin
                  $error("entry_count: expected %0d, got %0d", want.count, rsp_entry_count);
                  mismatch_count++;
               end
               if (rsp_capacity_now !== want.cap) begin
                  $error("capacity_now: expected %0d, got %0d", want.cap, rsp_capacity_now);
                  mismatch_count++;
               end
            end
            rsp_gap = idle_gap(rsp_quiet);
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // watchdog: nothing accepted on either side for too long
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin
      mix_type     mix;
      int unsigned phase_left;
      int unsigned useful;
      int unsigned roll;
      bit          drain;
      logic [OP_W-1:0] op;

      // directed: empty-list errors first
      plan(OP_POP,    any_pos(), $urandom, 1'b0);                    // pop on empty
      plan(OP_REMOVE, 7'd0, $urandom, 1'b0);                         // remove on empty
      plan(OP_LOOKUP, 7'd0, $urandom, 1'b0);
      plan(OP_INSERT, 7'd1, $urandom, 1'b0);                         // past the end
      plan(OP_INSERT, POS_MAX, $urandom, 1'b0);
      // build a short list with extreme words, growing the capacity along the way
      plan(OP_PUSH,   any_pos(), 32'sh7fff_ffff, 1'b0);
      plan(OP_INSERT, 7'd0, 32'sh8000_0000, 1'b0);                   // at the front
      plan(OP_INSERT, 7'd1, 32'sd0, 1'b0);                           // in the middle
      plan(OP_PUSH,   any_pos(), -32'sd1, 1'b0);
      plan(OP_INSERT, 7'd4, 32'sh5555_aaaa, 1'b0);                   // at the end
      plan(OP_LOOKUP, 7'd0, $urandom, 1'b0);
      plan(OP_LOOKUP, 7'd4, $urandom, 1'b0);
      plan(OP_LOOKUP, 7'd5, $urandom, 1'b0);                         // one past last
      plan(OP_LOOKUP, POS_MAX, $urandom, 1'b0);
      // spare codes
      for (op = OP_SPARE_LO; op <= OP_SPARE_HI && op >= OP_SPARE_LO; op++)
         plan(op, any_pos(), $urandom, 1'b0);
      // remove back down to empty, shrinking the capacity on the way
      plan(OP_REMOVE, 7'd2, $urandom, 1'b0);
      plan(OP_REMOVE, 7'd0, $urandom, 1'b0);
      plan(OP_REMOVE, POS_MAX, $urandom, 1'b0);
      plan(OP_POP, any_pos(), $urandom, 1'b0);
      plan(OP_POP, any_pos(), $urandom, 1'b0);
      plan(OP_POP, any_pos(), $urandom, 1'b0);
      plan(OP_POP, any_pos(), $urandom, 1'b0);                       // underflow again

      // random: phases that grow, shrink or churn the list; the first one
      // waits for the directed replies and fills toward the depth limit
      mix        = MIX_GROW;
      phase_left = 140;
      drain      = 1'b1;
      useful     = 0;
      while (useful < RANDOM_ITEMS) begin
         if (phase_left == 0) begin
            mix        = mix_type'($urandom_range(2, 0));
            phase_left = $urandom_range(160, 40);
            drain      = ($urandom_range(7, 0) == 0);   // now and then let it run dry
         end
         phase_left--;
         roll = $urandom_range(99, 0);
         // shift the roll so that each phase favors its own class of op
         if (mix == MIX_GROW) roll = (roll < 65) ? 0 : (roll < 80) ? 50 : (roll < 95) ? 80 : 99;
         else if (mix == MIX_SHRINK)
            roll = (roll < 15) ? 0 : (roll < 80) ? 50 : (roll < 95) ? 80 : 99;
         else roll = (roll < 40) ? 0 : (roll < 75) ? 50 : (roll < 95) ? 80 : 99;
         if (roll == 0) begin
            if ($urandom_range(1, 0)) plan(OP_INSERT, insert_pos(), $urandom, drain);
            else plan(OP_PUSH, any_pos(), $urandom, drain);
            useful++;
         end else if (roll == 50) begin
            if ($urandom_range(1, 0)) plan(OP_REMOVE, entry_pos(), $urandom, drain);
            else plan(OP_POP, any_pos(), $urandom, drain);
            useful++;
         end else if (roll == 80) begin
            plan(OP_LOOKUP, entry_pos(), $urandom, drain);
            useful++;
         end else begin
            // noise: spare code with a random position
            plan(OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO)), any_pos(),
                 $urandom, drain);
         end
         drain = 1'b0;
      end

      // reset, then let the driver work through the plan
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_words.size() > 0 || req_push || expected_replies.size() > 0)
         @(posedge clock);
      // stray replies would show up here
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_replies.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/fcil_pkg.sv
rtl/fcil_ram.sv
rtl/fcil_front.sv
rtl/fcil_back.sv
rtl/fibonacci_capacity_insert_list_top.sv
rtl/fcil_checker.sv
tb/tb_fibonacci_capacity_insert_list_top.sv
